// ===== rtl/sm3_pkg.sv =====
// Package: SM3 constants, types and round helper functions.
`timescale 1ns / 1ps
package sm3_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV0 = 32'h7380166F;
  localparam word_t IV1 = 32'h4914B2B9;
  localparam word_t IV2 = 32'h172442D7;
  localparam word_t IV3 = 32'hDA8A0600;
  localparam word_t IV4 = 32'hA96F30BC;
  localparam word_t IV5 = 32'h163138AA;
  localparam word_t IV6 = 32'hE38DEE4D;
  localparam word_t IV7 = 32'hB0FB0E4E;
  localparam word_t TJ_LOW  = 32'h79CC4519;
  localparam word_t TJ_HIGH = 32'h7A879D8A;
  localparam word_t PAD_WORD = 32'h80000000;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_payload_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_payload_t;

  typedef struct packed {
    logic start;
  } round_ctl_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== rtl/sm3_stream_if.sv =====
// Interface: valid/ready channel with a generic payload.
`timescale 1ns / 1ps
interface sm3_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sm3_round.sv =====
// Compression unit: one SM3 round per cycle over a 16-word expansion window.
`timescale 1ns / 1ps
module sm3_round (
  input  logic                 clk,
  input  logic                 rst,
  input  sm3_pkg::round_ctl_t  ctl,
  input  sm3_pkg::word_t       block [16],
  input  sm3_pkg::word_t       cv_in [8],
  output sm3_pkg::word_t       cv_out [8],
  output logic                 done
);
  sm3_pkg::word_t w [16];
  sm3_pkg::word_t r [8];
  logic [5:0] j;
  logic       running;
  logic [5:0] ahead;
  sm3_pkg::word_t expand, wj, wj4, tj, a12, ss1, ss2, tt1, tt2, ff, gg;

  always_comb begin
    ahead  = j + 6'd4;
    expand = sm3_pkg::perm1(w[ahead[3:0]] ^ w[ahead[3:0] - 4'd9] ^
               sm3_pkg::rotl(w[ahead[3:0] - 4'd3], 5'd15)) ^
             sm3_pkg::rotl(w[ahead[3:0] - 4'd13], 5'd7) ^ w[ahead[3:0] - 4'd6];
    wj  = w[j[3:0]];
    wj4 = (j >= 6'd12) ? expand : w[ahead[3:0]];
    tj  = (j < 6'd16) ? sm3_pkg::TJ_LOW : sm3_pkg::TJ_HIGH;
    a12 = sm3_pkg::rotl(r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + r[4] + sm3_pkg::rotl(tj, j[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (wj ^ wj4);
    tt2 = gg + r[7] + ss1 + wj;
    for (int k = 0; k < 8; k++) cv_out[k] = cv_in[k] ^ r[k];
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int k = 0; k < 16; k++) w[k] <= block[k];
      for (int k = 0; k < 8; k++) r[k] <= cv_in[k];
    end else if (running) begin
      if (j >= 6'd12) w[ahead[3:0]] <= expand;
      r[3] <= r[2];
      r[2] <= sm3_pkg::rotl(r[1], 5'd9);
      r[1] <= r[0];
      r[0] <= tt1;
      r[7] <= r[6];
      r[6] <= sm3_pkg::rotl(r[5], 5'd19);
      r[5] <= r[4];
      r[4] <= sm3_pkg::perm0(tt2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      j       <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
        j       <= '0;
      end else if (running) begin
        j <= j + 6'd1;
        if (j == 6'd63) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/sm3_hash_engine_core.sv =====
// Top level: SM3 hash engine with word input and digest output streams.
//
// in_ch carries message words {message_word, valid_bytes, last_word};
// out_ch carries digest words {digest_word, digest_last}.
// A word is taken while in_ch is ready; every sixteenth word starts a
// compression: the shared round unit is loaded, runs 64 rounds one per
// cycle and flags completion, and the result is folded into the chaining
// value. in_ch is not ready during the compression and the fold. A last
// word injects padding words one per cycle, runs one or two compressions,
// then streams eight digest words, one per cycle while out_ch is ready; a
// stalled receiver holds the current word and in_ch stays not ready. After
// the eighth word the engine reloads the IV and accepts a new message.
// Reset (rst, synchronous) loads the IV and clears counts; no clearing
// pass is needed.
`timescale 1ns / 1ps
module sm3_hash_engine_core (
  input logic clk,
  input logic rst,
  sm3_stream_if.sink   in_ch,
  sm3_stream_if.source out_ch
);
  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [3:0]  word_position;
  logic [63:0] byte_count;
  logic        finishing;
  logic        pad_marked;
  logic        len_in_block;
  logic        start_comp;
  logic [2:0]  out_idx;
  sm3_pkg::word_t cv [8];
  sm3_pkg::word_t cv_new [8];
  sm3_pkg::word_t block [16];
  sm3_pkg::round_ctl_t ctl;
  logic        comp_done;

  logic [31:0] in_word;
  logic [2:0]  in_nb;
  logic        in_last;
  logic [2:0]  nb;
  logic [31:0] mask, marked;
  logic [63:0] bits;
  sm3_pkg::word_t push_val;
  logic        push;

  assign in_word = in_ch.payload.message_word;
  assign in_nb   = in_ch.payload.valid_bytes;
  assign in_last = in_ch.payload.last_word;
  assign in_ch.ready = (state == S_IN);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload.digest_word = cv[out_idx];
  assign out_ch.payload.digest_last = (out_idx == 3'd7);
  assign bits = byte_count << 3;

  sm3_round u_round (
    .clk(clk), .rst(rst), .ctl(ctl), .block(block),
    .cv_in(cv), .cv_out(cv_new), .done(comp_done)
  );

  always_comb begin
    nb = (in_nb > 3'd4) ? 3'd4 : in_nb;
    mask = (nb == 3'd0) ? 32'd0 : ~(32'hFFFFFFFF >> {nb[1:0] == 2'd0, nb[1:0], 3'b000});
    if (nb == 3'd4) mask = 32'hFFFFFFFF;
    marked = (in_word & mask) | ({24'd0, sm3_pkg::PAD_BYTE} << (5'd24 - {nb[1:0], 3'b000}));
    push = 1'b0;
    push_val = in_word;
    ctl.start = start_comp;
    if (state == S_IN && in_ch.valid) begin
      push = 1'b1;
      push_val = (in_last && nb != 3'd4) ? marked : in_word;
    end else if (state == S_PAD) begin
      push = 1'b1;
      if (!pad_marked) push_val = sm3_pkg::PAD_WORD;
      else if (len_in_block && word_position == 4'd14) push_val = bits[63:32];
      else if (len_in_block && word_position == 4'd15) push_val = bits[31:0];
      else push_val = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      block[word_position] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      word_position <= '0;
      byte_count <= '0;
      finishing <= 1'b0;
      pad_marked <= 1'b0;
      len_in_block <= 1'b0;
      start_comp <= 1'b0;
      out_idx <= '0;
      cv <= '{sm3_pkg::IV0, sm3_pkg::IV1, sm3_pkg::IV2, sm3_pkg::IV3,
              sm3_pkg::IV4, sm3_pkg::IV5, sm3_pkg::IV6, sm3_pkg::IV7};
    end else begin
      if (push) word_position <= word_position + 4'd1;
      // start the rounds once the sixteenth word sits in the buffer
      start_comp <= push && (word_position == 4'd15);
      case (state)
        S_IN: begin
          if (in_ch.valid) begin
            byte_count <= byte_count + (in_last ? {61'd0, nb} : 64'd4);
            if (in_last) begin
              finishing  <= 1'b1;
              pad_marked <= (nb != 3'd4);
              if (nb != 3'd4) len_in_block <= (word_position <= 4'd13);
            end
            if (word_position == 4'd15) state <= S_COMP;
            else if (in_last) state <= S_PAD;
          end
        end
        S_PAD: begin
          pad_marked <= 1'b1;
          // length words fit only if the pad marker leaves two free slots
          if (!pad_marked) len_in_block <= (word_position <= 4'd13);
          if (word_position == 4'd15) state <= S_COMP;
        end
        S_COMP: if (comp_done) state <= S_FOLD;
        S_FOLD: begin
          cv <= cv_new;
          if (!finishing) state <= S_IN;
          else if (len_in_block) state <= S_OUT;
          else begin
            len_in_block <= pad_marked;
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state <= S_IN;
              finishing <= 1'b0;
              pad_marked <= 1'b0;
              len_in_block <= 1'b0;
              byte_count <= '0;
              cv <= '{sm3_pkg::IV0, sm3_pkg::IV1, sm3_pkg::IV2, sm3_pkg::IV3,
                      sm3_pkg::IV4, sm3_pkg::IV5, sm3_pkg::IV6, sm3_pkg::IV7};
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_COMP |-> !in_ch.ready) else $error("input ready during compression");
  a_done_in_comp: assert property (@(posedge clk) disable iff (rst)
    comp_done |-> $past(state) == S_COMP) else $error("round done outside compression");
  a_out_order: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && out_idx != 3'd7 |=> out_idx == $past(out_idx) + 3'd1)
    else $error("digest word skipped");
`endif
endmodule
